// File: rtl/lalr_shift_reduce_engine_defines.svh
// Assertion macros shared by the shift-reduce engine RTL.
// No dependencies.
`ifndef LALR_SHIFT_REDUCE_ENGINE_DEFINES_SVH
`define LALR_SHIFT_REDUCE_ENGINE_DEFINES_SVH
// check that a condition implies a consequence in the same cycle
`define LSR_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// check that a condition implies a consequence in the next cycle
`define LSR_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: rtl/lsre_pkg.sv
// Package for the shift-reduce engine: sizes, codes and shared types.
// No dependencies.
package lsre_pkg;
  localparam int STACK_DEPTH = 64;
  localparam int NUM_STATES = 256;
  localparam int NUM_TERMS = 64;
  localparam int NUM_NONTERMS = 64;
  localparam int NUM_RULES = 128;
  localparam int MAX_REDUCES = 63;
  localparam int SP_W = 7;
  localparam int SA_W = 6;
  localparam int ACT_AW = 14;
  localparam int GOTO_AW = 14;

  localparam logic [1:0] CMD_TOKEN = 2'd0;
  localparam logic [1:0] CMD_ACTION = 2'd1;
  localparam logic [1:0] CMD_GOTO = 2'd2;
  localparam logic [1:0] CMD_RULE = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REDUCE = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;

  localparam logic [2:0] EV_SHIFT = 3'd0;
  localparam logic [2:0] EV_REDUCE = 3'd1;
  localparam logic [2:0] EV_ACCEPT = 3'd2;
  localparam logic [2:0] EV_NOACT = 3'd3;
  localparam logic [2:0] EV_CONFLICT = 3'd4;
  localparam logic [2:0] EV_OVERFLOW = 3'd5;
  localparam logic [2:0] EV_UNDERFLOW = 3'd6;
  localparam logic [2:0] EV_LIMIT = 3'd7;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] new_state;
    logic [6:0] rule_used;
    logic [3:0] pop_count;
    logic [5:0] lhs_symbol;
    logic [6:0] stack_level;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       act_we;
    logic       goto_we;
    logic       rule_we;
    logic [13:0] act_waddr;
    logic [13:0] goto_waddr;
    logic [6:0] rule_waddr;
    logic [8:0] shift_wdata;
    logic [8:0] reduce_wdata;
    logic [7:0] goto_wdata;
    logic [9:0] rule_wdata;
  } tbl_wr_t;
endpackage

// File: rtl/lalr_shift_reduce_engine.sv
// Top level of the table-driven shift-reduce engine: control sequencer,
// APB registers and stream ports. Depends on lsre_pkg, lsre_tables, lsre_stack and the defines header.
//
// Usage: s_axis carries requests in tdata. cmd 1..3 load the action, goto and
// rule tables and give no result. cmd 0 is a token: it gives one m_axis result
// for each reduce and a final result (tlast) for a shift, an accept or an error.
// Configuration (start_state at 0x0, accept_rule at 0x4) goes through APB; the user
// must write it only while idle, the block does not enforce this.
// After a token is taken, a shift or an error is found at the action read, an
// accept or an underflow at the rule read, and a reduce or an overflow at the goto
// (after the rule, stack and goto reads). Each further reduce repeats the action,
// rule, stack and goto reads, and the closing shift ends at its action read.
// s_axis_tready returns in the cycle after the final result is loaded.
// The top of stack is cached in a register so the action read starts at once.
// At reset the stack holds only state 0, the reset value of start_state (held in the top
// register; entry zero of the memory is written when the first shift or empty reduce pushes above it).
// A stalled receiver holds the result register; the sequencer waits until it
// has been taken before loading the next one. Tables are undefined until
// written. s_axis_tready is high only while no token is in progress.
module lalr_shift_reduce_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[1:0] term_index[7:2] row_state[15:8] nonterm_index[21:16]
  // shift_valid[22] shift_target[30:23] reduce_kind[32:31] rule_index[39:33]
  // rule_length[43:40] rule_lhs[49:44] goto_target[57:50], zero fill to 64
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // event_res[2:0] new_state[10:3] rule_used[17:11] pop_count[21:18]
  // lhs_symbol[27:22] stack_level[34:28], zero fill to 40
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "lalr_shift_reduce_engine_defines.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACT  = 3'd1;
  localparam logic [2:0] S_RULE = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_GOTO = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [7:0]  start_q;
  logic [6:0]  acc_rule_q;
  logic [6:0]  sp_q, sp_d;
  logic [7:0]  top_q, top_d;
  logic [5:0]  term_q, term_d;
  logic [5:0]  nred_q, nred_d;
  logic [6:0]  rule_q, rule_d;
  logic [3:0]  len_q, len_d;
  logic [5:0]  lhs_q, lhs_d;
  logic        acc_q, acc_d;
  lsre_pkg::result_t res_q, res_d;
  logic        oval_q, oval_d;

  lsre_pkg::tbl_wr_t wr;
  logic [8:0]  shift_rd, reduce_rd;
  logic [7:0]  goto_rd, stk_rd;
  logic [9:0]  rule_rd;
  logic [6:0]  rule_ra;
  logic        stk_we;
  logic [5:0]  stk_wa, stk_ra;
  logic [7:0]  stk_wd;

  logic [1:0]  in_cmd;
  logic        in_acc;
  logic [1:0]  kind;
  logic [6:0]  sp_pop;
  logic [3:0]  len_rd;
  logic [6:0]  sp_below;
  logic [7:0]  below;
  logic [7:0]  goto_row;

  assign in_cmd = s_axis_tdata[1:0];
  assign s_axis_tready = (st_q == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, start_q} : {25'd0, acc_rule_q};

  always_comb begin
    wr = '0;
    wr.act_we = in_acc && in_cmd == lsre_pkg::CMD_ACTION;
    wr.goto_we = in_acc && in_cmd == lsre_pkg::CMD_GOTO;
    wr.rule_we = in_acc && in_cmd == lsre_pkg::CMD_RULE;
    wr.act_waddr = {s_axis_tdata[15:8], s_axis_tdata[7:2]};
    wr.goto_waddr = {s_axis_tdata[15:8], s_axis_tdata[21:16]};
    wr.rule_waddr = s_axis_tdata[39:33];
    wr.shift_wdata = {s_axis_tdata[22], s_axis_tdata[30:23]};
    wr.reduce_wdata = {s_axis_tdata[32:31], s_axis_tdata[39:33]};
    wr.goto_wdata = s_axis_tdata[57:50];
    wr.rule_wdata = {s_axis_tdata[43:40], s_axis_tdata[49:44]};
  end

  assign kind = (reduce_rd[8:7] == 2'd3) ? lsre_pkg::KIND_NONE : reduce_rd[8:7];
  assign rule_ra = (kind == lsre_pkg::KIND_ACCEPT) ? acc_rule_q : reduce_rd[6:0];
  assign sp_pop = sp_q - {3'd0, len_q};

  // start the read of the state below the popped symbols as soon as the length is known
  assign len_rd = (st_q == S_RULE) ? rule_rd[9:6] : len_q;
  assign sp_below = sp_q - {3'd0, len_rd};
  assign stk_ra = sp_below[5:0] - 6'd1;

  // goto read needs the state below the popped symbols; with len 0 it is top
  assign below = stk_rd;
  assign goto_row = (len_q == 4'd0) ? top_q : below;

  lsre_tables u_tables (
    .clk_i(clk_i), .wr_i(wr),
    .act_raddr_i({top_d, term_d}),
    .goto_raddr_i({goto_row, lhs_q}),
    .rule_raddr_i(rule_ra),
    .shift_o(shift_rd), .reduce_o(reduce_rd), .goto_o(goto_rd), .rule_o(rule_rd)
  );

  lsre_stack u_stack (
    .clk_i(clk_i), .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  always_comb begin
    st_d = st_q; sp_d = sp_q; top_d = top_q; term_d = term_q; nred_d = nred_q;
    rule_d = rule_q; len_d = len_q; lhs_d = lhs_q; acc_d = acc_q;
    res_d = res_q; oval_d = oval_q;
    stk_we = 1'b0; stk_wa = sp_q[5:0] - 6'd1; stk_wd = top_q;
    if (oval_q && m_axis_tready) oval_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_acc && in_cmd == lsre_pkg::CMD_TOKEN) begin
          term_d = s_axis_tdata[7:2];
          nred_d = '0;
          st_d = S_ACT;
        end
      end
      S_ACT: begin
        if (!oval_q || m_axis_tready) begin
          res_d = '0;
          res_d.new_state = start_q;
          res_d.stack_level = 7'd1;
          res_d.last = 1'b1;
          if (!shift_rd[8] && kind == lsre_pkg::KIND_NONE) begin
            res_d.event_res = lsre_pkg::EV_NOACT; st_d = S_OUT;
          end else if (shift_rd[8] && kind != lsre_pkg::KIND_NONE) begin
            res_d.event_res = lsre_pkg::EV_CONFLICT; st_d = S_OUT;
          end else if (kind == lsre_pkg::KIND_NONE) begin
            if (sp_q >= 7'(lsre_pkg::STACK_DEPTH)) begin
              res_d.event_res = lsre_pkg::EV_OVERFLOW; st_d = S_OUT;
            end else begin
              stk_we = 1'b1; stk_wa = sp_q[5:0] - 6'd1; stk_wd = top_q;
              top_d = shift_rd[7:0];
              sp_d = sp_q + 7'd1;
              res_d.event_res = lsre_pkg::EV_SHIFT;
              res_d.new_state = shift_rd[7:0];
              res_d.stack_level = sp_q + 7'd1;
              st_d = S_OUT;
            end
          end else begin
            acc_d = (kind == lsre_pkg::KIND_ACCEPT);
            rule_d = rule_ra;
            if (kind == lsre_pkg::KIND_REDUCE && nred_q >= 6'(lsre_pkg::MAX_REDUCES)) begin
              res_d.event_res = lsre_pkg::EV_LIMIT; st_d = S_OUT;
            end else st_d = S_RULE;
          end
        end
      end
      S_RULE: begin
        len_d = rule_rd[9:6]; lhs_d = rule_rd[5:0];
        res_d = '0;
        res_d.new_state = start_q; res_d.stack_level = 7'd1; res_d.last = 1'b1;
        if ({3'd0, rule_rd[9:6]} >= sp_q) begin
          res_d.event_res = lsre_pkg::EV_UNDERFLOW; st_d = S_OUT;
        end else if (acc_q) begin
          res_d.event_res = lsre_pkg::EV_ACCEPT;
          res_d.rule_used = rule_q; res_d.pop_count = rule_rd[9:6];
          st_d = S_OUT;
        end else st_d = S_POP;
      end
      S_POP: begin
        st_d = S_GOTO;
      end
      S_GOTO: begin
        if (oval_q) st_d = S_GOTO;
        else if (len_q == 4'd0 && sp_q >= 7'(lsre_pkg::STACK_DEPTH)) begin
          res_d = '0;
          res_d.event_res = lsre_pkg::EV_OVERFLOW;
          res_d.new_state = start_q; res_d.stack_level = 7'd1; res_d.last = 1'b1;
          st_d = S_OUT;
        end else begin
          st_d = S_ACT;
          res_d = '0;
          res_d.event_res = lsre_pkg::EV_REDUCE;
          res_d.rule_used = rule_q; res_d.pop_count = len_q; res_d.lhs_symbol = lhs_q;
          res_d.new_state = goto_rd;
          res_d.stack_level = sp_pop + 7'd1;
          if (len_q == 4'd0) begin
            stk_we = 1'b1; stk_wa = sp_q[5:0] - 6'd1; stk_wd = top_q;
          end
          top_d = goto_rd;
          sp_d = sp_pop + 7'd1;
          nred_d = nred_q + 6'd1;
          oval_d = 1'b1;
        end
      end
      S_OUT: begin
        if (!oval_q) begin
          oval_d = 1'b1;
          if (res_d.last && res_d.event_res != lsre_pkg::EV_SHIFT) begin
            sp_d = 7'd1; top_d = start_q;
          end
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; sp_q <= 7'd1; top_q <= '0; start_q <= '0; acc_rule_q <= '0;
      oval_q <= 1'b0; nred_q <= '0; acc_q <= 1'b0;
    end else begin
      st_q <= st_d; sp_q <= sp_d; top_q <= top_d; oval_q <= oval_d;
      nred_q <= nred_d; acc_q <= acc_d;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == 1'b0) start_q <= pwdata[7:0];
        else acc_rule_q <= pwdata[6:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d; rule_q <= rule_d; len_q <= len_d; lhs_q <= lhs_d;
    res_q <= res_d;
  end

  assign m_axis_tvalid = oval_q;
  assign m_axis_tlast = res_q.last;
  assign m_axis_tdata = {5'd0, res_q.stack_level, res_q.lhs_symbol, res_q.pop_count,
                         res_q.rule_used, res_q.new_state, res_q.event_res};

  `LSR_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, st_q != S_IDLE, !s_axis_tready)
  `LSR_ASSERT_IMP(a_sp_range, clk_i, rst_ni, 1'b1,
                  sp_q >= 7'd1 && sp_q <= 7'(lsre_pkg::STACK_DEPTH))
  `LSR_ASSERT_NXT(a_hold, clk_i, rst_ni, oval_q && !m_axis_tready, oval_q && $stable(res_q))
endmodule

// File: rtl/lsre_tables.sv
// Parse table memories: action, goto and rule info, registered reads.
// Depends on lsre_pkg.
module lsre_tables (
  input  logic                 clk_i,
  input  lsre_pkg::tbl_wr_t    wr_i,
  input  logic [13:0]          act_raddr_i,
  input  logic [13:0]          goto_raddr_i,
  input  logic [6:0]           rule_raddr_i,
  output logic [8:0]           shift_o,
  output logic [8:0]           reduce_o,
  output logic [7:0]           goto_o,
  output logic [9:0]           rule_o
);
  logic [17:0] act_mem [lsre_pkg::NUM_STATES*lsre_pkg::NUM_TERMS];
  logic [7:0]  goto_mem [lsre_pkg::NUM_STATES*lsre_pkg::NUM_NONTERMS];
  logic [9:0]  rule_mem [lsre_pkg::NUM_RULES];
  logic [17:0] act_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.act_we) act_mem[wr_i.act_waddr] <= {wr_i.shift_wdata, wr_i.reduce_wdata};
    act_q <= act_mem[act_raddr_i];
  end
  always_ff @(posedge clk_i) begin
    if (wr_i.goto_we) goto_mem[wr_i.goto_waddr] <= wr_i.goto_wdata;
    goto_o <= goto_mem[goto_raddr_i];
  end
  always_ff @(posedge clk_i) begin
    if (wr_i.rule_we) rule_mem[wr_i.rule_waddr] <= wr_i.rule_wdata;
    rule_o <= rule_mem[rule_raddr_i];
  end
  assign shift_o = act_q[17:9];
  assign reduce_o = act_q[8:0];
endmodule

// File: rtl/lsre_stack.sv
// State stack memory with one write port and a registered read port.
// Depends on lsre_pkg.
module lsre_stack (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [5:0]  waddr_i,
  input  logic [7:0]  wdata_i,
  input  logic [5:0]  raddr_i,
  output logic [7:0]  rdata_o
);
  logic [7:0] mem [lsre_pkg::STACK_DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
